### design/quadratic_outline_point_decoder_macros.svh
// Assertion macros for the outline point decoder.
`ifndef QUADRATIC_OUTLINE_POINT_DECODER_MACROS_SVH
`define QUADRATIC_OUTLINE_POINT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QOPD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("outline decoder check failed");

// Next-cycle implication, checked outside reset.
`define QOPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("outline decoder check failed");

`endif

### design/qopd_pkg.sv
// Shared types and constants of the outline point decoder.
package qopd_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RawW   = 16;
  localparam int unsigned FlagW  = 8;

  localparam int unsigned FLAG_ON_CURVE = 0;
  localparam int unsigned FLAG_X_SHORT  = 1;
  localparam int unsigned FLAG_Y_SHORT  = 2;
  localparam int unsigned FLAG_X_SAME   = 4;
  localparam int unsigned FLAG_Y_SAME   = 5;

  localparam logic [CoordW-1:0] SCALE_RESET  = 32'h0001_0000;
  localparam logic [CoordW-1:0] OFFSET_RESET = 32'h0000_0000;

  typedef enum logic [1:0] {
    REG_X_SCALE  = 2'd0,
    REG_Y_SCALE  = 2'd1,
    REG_X_OFFSET = 2'd2,
    REG_Y_OFFSET = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_CTRL  = 2'd2
  } phase_t;

  typedef enum logic {
    SEG_LINE  = 1'b0,
    SEG_CURVE = 1'b1
  } seg_kind_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              on_curve;
    logic              last;
  } pt_t;

  typedef struct packed {
    seg_kind_t         kind;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] ex;
    logic [CoordW-1:0] ey;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              bad;
    logic              last;
  } seg_t;

endpackage

### design/quadratic_outline_point_decoder.sv
// Top level of the quadratic outline point decoder.
//
// Takes one glyph outline point per cycle and returns line and quadratic curve
// segments in Q16.16. A point passes three registered stages: coordinate decode
// into running font units, a 32x32 multiply by the scale registers, then offset,
// contour machine and a two-entry result queue that drives the output. Points that
// yield zero or one segment flow at one per cycle while the output is ready;
// a point that also closes its contour yields two segments and holds the input
// while the queue drains, since the output moves one segment per cycle. Scale
// and offset registers are written through the cfg port (always ready) and
// should only change while the block holds no points.
`include "quadratic_outline_point_decoder_macros.svh"

module quadratic_outline_point_decoder import qopd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // point_flags[7:0], x_raw[23:8], y_raw[39:24]
  input  logic [39:0]  in_tdata,
  // glyph_first
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, end_x, end_y, ctrl_x, ctrl_y from bit 0 up, 32 bits each
  output logic [191:0] out_tdata,
  // seg_kind[0], bad_start[1]
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [CoordW-1:0] x_scale_r, y_scale_r, x_offset_r, y_offset_r;
  logic              dec_valid, dec_ready, scl_valid, scl_ready;
  pt_t               dec_pt, scl_pt;
  seg_t              seg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r  <= SCALE_RESET;
      y_scale_r  <= SCALE_RESET;
      x_offset_r <= OFFSET_RESET;
      y_offset_r <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_SCALE:  x_scale_r  <= cfg_data;
        REG_Y_SCALE:  y_scale_r  <= cfg_data;
        REG_X_OFFSET: x_offset_r <= cfg_data;
        REG_Y_OFFSET: y_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qopd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .flags        (in_tdata[7:0]),
    .x_raw        (in_tdata[23:8]),
    .y_raw        (in_tdata[39:24]),
    .glyph_first  (in_tuser),
    .contour_last (in_tlast),
    .out_valid    (dec_valid),
    .out_ready    (dec_ready),
    .out_pt       (dec_pt)
  );

  qopd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_pt     (dec_pt),
    .x_scale   (x_scale_r),
    .y_scale   (y_scale_r),
    .out_valid (scl_valid),
    .out_ready (scl_ready),
    .out_pt    (scl_pt)
  );

  qopd_contour u_contour (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_pt     (scl_pt),
    .x_offset  (x_offset_r),
    .y_offset  (y_offset_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_seg   (seg)
  );

  assign out_tdata = {seg.cy, seg.cx, seg.ey, seg.ex, seg.sy, seg.sx};
  assign out_tuser = {seg.bad, seg.kind};
  assign out_tlast = seg.last;

  `QOPD_ASSERT_IMPLIES(a_bad_is_blank, out_tvalid && out_tuser[1], out_tdata == '0 && !out_tuser[0])
  `QOPD_ASSERT_IMPLIES(a_line_no_ctrl, out_tvalid && !out_tuser[0], out_tdata[191:128] == '0)
  `QOPD_ASSERT_IMPLIES(a_stall_when_full, !in_tready, dec_valid && !dec_ready)
  `QOPD_ASSERT_NEXT(a_dec_holds, dec_valid && !dec_ready, dec_valid && $stable(dec_pt))

endmodule

### design/qopd_decode.sv
// Coordinate decode stage: running font-unit point and input register.
module qopd_decode import qopd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [FlagW-1:0] flags,
  input  logic [RawW-1:0]  x_raw,
  input  logic [RawW-1:0]  y_raw,
  input  logic             glyph_first,
  input  logic             contour_last,
  output logic             out_valid,
  input  logic             out_ready,
  output pt_t              out_pt
);

  function automatic logic [CoordW-1:0] dec_coord(input logic [CoordW-1:0] prev,
                                                  input logic [RawW-1:0]   raw,
                                                  input logic              is_short,
                                                  input logic              same);
    logic [CoordW-1:0] d;
    if (is_short) begin
      d = {{(CoordW-8){1'b0}}, raw[7:0]};
      if (!same) d = -d;
    end else if (!same) begin
      d = {{(CoordW-RawW){raw[RawW-1]}}, raw};
    end else begin
      d = '0;
    end
    return prev + d;
  endfunction

  logic [CoordW-1:0] prev_x_r, prev_y_r, prev_x_nxt, prev_y_nxt;
  logic [CoordW-1:0] base_x, base_y;
  logic              valid_r;
  pt_t               pt_r;
  logic              fire;

  assign in_ready  = !valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_pt    = pt_r;

  always_comb begin
    base_x     = glyph_first ? '0 : prev_x_r;
    base_y     = glyph_first ? '0 : prev_y_r;
    prev_x_nxt = dec_coord(base_x, x_raw, flags[FLAG_X_SHORT], flags[FLAG_X_SAME]);
    prev_y_nxt = dec_coord(base_y, y_raw, flags[FLAG_Y_SHORT], flags[FLAG_Y_SAME]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else if (fire) begin
      valid_r  <= 1'b1;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
    end else if (out_ready) begin
      valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pt_r.x        <= prev_x_nxt;
      pt_r.y        <= prev_y_nxt;
      pt_r.on_curve <= flags[FLAG_ON_CURVE];
      pt_r.last     <= contour_last;
    end
  end

endmodule

### design/qopd_scale.sv
// Scale stage: font units times Q16.16 scale, low 32 bits registered.
module qopd_scale import qopd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pt_t               in_pt,
  input  logic [CoordW-1:0] x_scale,
  input  logic [CoordW-1:0] y_scale,
  output logic              out_valid,
  input  logic              out_ready,
  output pt_t               out_pt
);

  logic              valid_r;
  pt_t               pt_r;
  logic              fire;
  logic [CoordW-1:0] prod_x, prod_y;

  assign in_ready  = !valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_pt    = pt_r;

  // low half of a two's complement product does not depend on signedness
  assign prod_x = CoordW'(in_pt.x * x_scale);
  assign prod_y = CoordW'(in_pt.y * y_scale);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pt_r.x        <= prod_x;
      pt_r.y        <= prod_y;
      pt_r.on_curve <= in_pt.on_curve;
      pt_r.last     <= in_pt.last;
    end
  end

endmodule

### design/qopd_contour.sv
// Contour machine: offset, segment building, and a two-entry result queue.
module qopd_contour import qopd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pt_t               in_pt,
  input  logic [CoordW-1:0] x_offset,
  input  logic [CoordW-1:0] y_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output seg_t              out_seg
);

  phase_t            phase_r, phase_nxt, phase_mid;
  logic [CoordW-1:0] ps_x_r, ps_y_r, ps_x_nxt, ps_y_nxt;
  logic [CoordW-1:0] pc_x_r, pc_y_r, pc_x_nxt, pc_y_nxt;
  logic [CoordW-1:0] org_x_r, org_y_r, org_x_nxt, org_y_nxt;
  logic [CoordW-1:0] px, py, mid_x, mid_y;
  logic [CoordW:0]   sum_x, sum_y;

  seg_t              q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              pop, fire;

  seg_t              res_a, res_b;
  logic              emit_a;

  assign px    = in_pt.x + x_offset;
  assign py    = in_pt.y + y_offset;
  assign sum_x = {pc_x_r[CoordW-1], pc_x_r} + {px[CoordW-1], px};
  assign sum_y = {pc_y_r[CoordW-1], pc_y_r} + {py[CoordW-1], py};
  assign mid_x = sum_x[CoordW:1];
  assign mid_y = sum_y[CoordW:1];

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign fire      = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_seg   = q0_r;

  // next contour state
  always_comb begin
    phase_mid = phase_r;
    ps_x_nxt  = ps_x_r;
    ps_y_nxt  = ps_y_r;
    pc_x_nxt  = pc_x_r;
    pc_y_nxt  = pc_y_r;
    org_x_nxt = org_x_r;
    org_y_nxt = org_y_r;
    case (phase_r)
      PH_START: begin
        if (in_pt.on_curve) begin
          ps_x_nxt = px;
          ps_y_nxt = py;
        end else begin
          pc_x_nxt  = px;
          pc_y_nxt  = py;
          phase_mid = PH_CTRL;
        end
      end
      PH_CTRL: begin
        if (in_pt.on_curve) begin
          ps_x_nxt  = px;
          ps_y_nxt  = py;
          phase_mid = PH_START;
        end else begin
          ps_x_nxt = mid_x;
          ps_y_nxt = mid_y;
          pc_x_nxt = px;
          pc_y_nxt = py;
        end
      end
      default: begin
        ps_x_nxt  = px;
        ps_y_nxt  = py;
        org_x_nxt = px;
        org_y_nxt = py;
        phase_mid = PH_START;
      end
    endcase
    phase_nxt = in_pt.last ? PH_IDLE : phase_mid;
  end

  // segments produced by this point and by the closing step
  always_comb begin
    emit_a = 1'b0;
    res_a  = '0;
    res_b  = '0;
    case (phase_r)
      PH_START: begin
        if (in_pt.on_curve) begin
          emit_a   = 1'b1;
          res_a.sx = ps_x_r;
          res_a.sy = ps_y_r;
          res_a.ex = px;
          res_a.ey = py;
        end
      end
      PH_CTRL: begin
        emit_a     = 1'b1;
        res_a.kind = SEG_CURVE;
        res_a.sx   = ps_x_r;
        res_a.sy   = ps_y_r;
        res_a.ex   = in_pt.on_curve ? px : mid_x;
        res_a.ey   = in_pt.on_curve ? py : mid_y;
        res_a.cx   = pc_x_r;
        res_a.cy   = pc_y_r;
      end
      default: begin
        emit_a    = !in_pt.on_curve;
        res_a.bad = 1'b1;
      end
    endcase
    res_a.last = !in_pt.last;

    res_b.sx   = ps_x_nxt;
    res_b.sy   = ps_y_nxt;
    res_b.ex   = org_x_nxt;
    res_b.ey   = org_y_nxt;
    res_b.last = 1'b1;
    if (phase_mid == PH_CTRL) begin
      res_b.kind = SEG_CURVE;
      res_b.cx   = pc_x_nxt;
      res_b.cy   = pc_y_nxt;
    end
  end

  // result queue, head at q0
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
    if (fire) begin
      if (emit_a) begin
        q0_nxt  = res_a;
        q1_nxt  = res_b;
        cnt_nxt = in_pt.last ? 2'd2 : 2'd1;
      end else if (in_pt.last) begin
        q0_nxt  = res_b;
        cnt_nxt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (fire) begin
      ps_x_r  <= ps_x_nxt;
      ps_y_r  <= ps_y_nxt;
      pc_x_r  <= pc_x_nxt;
      pc_y_r  <= pc_y_nxt;
      org_x_r <= org_x_nxt;
      org_y_r <= org_y_nxt;
    end
  end

endmodule
